### rtl/core/mfrag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message fragmenter package
// Shared constants, the header kind code and the command word passed from the
// front end to the byte emitter.
// ----------------------------------------------------------------------------
package mfrag_pkg;

	localparam int PACKET_SIZE_DEF = 128;
	localparam int MULTI_HDR_LEN   = 14;
	localparam int CMD_FIFO_DEPTH  = 4;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SINGLE_TYPE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MULTI_TYPE  = 1'b1;

	localparam logic [7:0] SINGLE_TYPE_RST = 8'd0;
	localparam logic [7:0] MULTI_TYPE_RST  = 8'd1;

	// step counter of the emitter: up to the fourteen header bytes plus the data
	localparam int STEP_W = 4;

	typedef enum logic [1:0] {
		HDR_NONE   = 2'b00,
		HDR_SINGLE = 2'b01,
		HDR_MULTI  = 2'b10
	} hdr_kind_t;

	typedef struct packed {
		logic [7:0] single_type;
		logic [7:0] multi_type;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  data;
		logic [15:0] sender;
		logic        pend;
		hdr_kind_t   kind;
		logic [7:0]  type_byte;
		logic [7:0]  len_byte;
		logic [31:0] msg_id;
		logic [15:0] frag_index;
		logic [15:0] frag_total;
	} cmd_t;

	localparam logic [STEP_W-1:0] LAST_STEP_NONE   = 4'd0;
	localparam logic [STEP_W-1:0] LAST_STEP_SINGLE = 4'd2;
	localparam logic [STEP_W-1:0] LAST_STEP_MULTI  = 4'd14;

endpackage

### rtl/core/mfrag_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message fragmenter front end
// Accepts payload words, tracks message and fragment position, and builds one
// command word per input word. The fragment total is a reciprocal multiply
// registered in the first stage.
// ----------------------------------------------------------------------------
module mfrag_front import mfrag_pkg::*; #(
	parameter int PACKET_SIZE = PACKET_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic [15:0] sender_id,
	input  logic [15:0] message_length,
	input  cfg_t        cfg,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);

	localparam int FRAG_MAX_INT = PACKET_SIZE - MULTI_HDR_LEN;
	localparam logic [15:0] FRAG_MAX   = 16'(FRAG_MAX_INT);
	localparam logic [15:0] SINGLE_MAX = 16'(PACKET_SIZE - 2);
	// exact ceil quotient for a 17-bit numerator and an 8-bit divisor
	localparam int RCP_SHIFT = 25;
	localparam int NUM_W     = 17;
	localparam int MUL_W     = NUM_W + RCP_SHIFT;
	localparam logic [RCP_SHIFT-1:0] RCP =
		RCP_SHIFT'(((2 ** RCP_SHIFT) + FRAG_MAX_INT - 1) / FRAG_MAX_INT);

	logic [31:0] msg_cnt_q;
	logic [15:0] byte_pos_q;
	logic [7:0]  frag_pos_q;
	logic [15:0] frag_idx_q;
	logic [15:0] frag_total_q;
	logic        split_q;

	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [15:0] quot_s1;
	logic        load_total_s1;

	logic        accept;
	logic        push;
	logic [15:0] len_e;
	logic        first;
	logic [15:0] remaining;
	logic        msg_end;
	logic        split;
	logic [7:0]  frag_pos;
	logic [15:0] frag_idx;
	logic [7:0]  flen;
	logic        frag_end;
	hdr_kind_t   kind;
	logic [NUM_W-1:0] numer;
	logic [MUL_W-1:0] prod;

	assign accept   = in_valid && in_ready;
	assign push     = valid_s1 && cmd_ready;
	assign in_ready = !valid_s1 || cmd_ready;

	always_comb begin
		len_e     = (message_length == 16'd0) ? 16'd1 : message_length;
		first     = (byte_pos_q == 16'd0);
		remaining = (byte_pos_q < len_e) ? (len_e - byte_pos_q) : 16'd1;
		msg_end   = (remaining == 16'd1);
		split     = first ? (len_e > SINGLE_MAX) : split_q;
		frag_pos  = first ? 8'd0 : frag_pos_q;
		frag_idx  = first ? 16'd0 : frag_idx_q;
		flen      = (remaining < FRAG_MAX) ? remaining[7:0] : FRAG_MAX[7:0];
		frag_end  = msg_end || (({1'b0, frag_pos} + 9'd1) >= FRAG_MAX[8:0]);
		if (split) begin
			kind = (frag_pos == 8'd0) ? HDR_MULTI : HDR_NONE;
		end else begin
			kind = first ? HDR_SINGLE : HDR_NONE;
		end
		numer = NUM_W'(len_e) + NUM_W'(FRAG_MAX) - NUM_W'(1);
		prod  = MUL_W'(numer) * MUL_W'(RCP);
	end

	// message and fragment position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_cnt_q  <= '0;
			byte_pos_q <= '0;
			frag_pos_q <= '0;
			frag_idx_q <= '0;
			split_q    <= 1'b0;
		end else if (accept) begin
			if (msg_end) begin
				if (split) begin
					msg_cnt_q <= msg_cnt_q + 32'd1;
				end
				byte_pos_q <= '0;
				frag_pos_q <= '0;
				frag_idx_q <= '0;
				split_q    <= 1'b0;
			end else begin
				byte_pos_q <= byte_pos_q + 16'd1;
				split_q    <= split;
				if (split && frag_end) begin
					frag_pos_q <= '0;
					frag_idx_q <= frag_idx + 16'd1;
				end else begin
					frag_pos_q <= frag_pos + 8'd1;
					frag_idx_q <= frag_idx;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			frag_total_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
			if (push && load_total_s1) begin
				frag_total_q <= quot_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.data       <= data_byte;
			cmd_s1.sender     <= sender_id;
			cmd_s1.pend       <= split ? frag_end : msg_end;
			cmd_s1.kind       <= kind;
			cmd_s1.type_byte  <= split ? cfg.multi_type : cfg.single_type;
			cmd_s1.len_byte   <= split ? flen : len_e[7:0];
			cmd_s1.msg_id     <= msg_cnt_q;
			cmd_s1.frag_index <= frag_idx;
			cmd_s1.frag_total <= '0;
			quot_s1           <= prod[RCP_SHIFT+15:RCP_SHIFT];
			load_total_s1     <= first && split;
		end
	end

	always_comb begin
		cmd            = cmd_s1;
		cmd.frag_total = load_total_s1 ? quot_s1 : frag_total_q;
	end

	assign cmd_valid = valid_s1;

endmodule

### rtl/core/mfrag_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message fragmenter command queue
// Short first-in first-out queue of command words between front end and
// byte emitter.
// ----------------------------------------------------------------------------
module mfrag_fifo import mfrag_pkg::*; #(
	parameter int DEPTH = CMD_FIFO_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### rtl/core/mfrag_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message fragmenter byte emitter
// Walks each command word through its header bytes and payload byte, one
// output word per cycle while out_ready allows, into a registered output stage.
// ----------------------------------------------------------------------------
module mfrag_back import mfrag_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic [15:0] out_sender,
	output logic        packet_end,
	output logic        run_last
);

	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic [15:0]       out_sender_q;
	logic              packet_end_q;
	logic              run_last_q;

	logic              load;
	logic              is_last;
	logic [STEP_W-1:0] last_step;
	logic [7:0]        sel_byte;

	assign load      = !out_valid_q || out_ready;
	assign is_last   = (step_q == last_step);
	assign cmd_ready = load && is_last;

	always_comb begin
		case (cmd.kind)
			HDR_SINGLE: last_step = LAST_STEP_SINGLE;
			HDR_MULTI:  last_step = LAST_STEP_MULTI;
			default:    last_step = LAST_STEP_NONE;
		endcase
	end

	// header layout: type, length, id (4), index (4), total (4), upper halves zero
	always_comb begin
		if (is_last) begin
			sel_byte = cmd.data;
		end else begin
			case (step_q)
				4'd0:    sel_byte = cmd.type_byte;
				4'd1:    sel_byte = cmd.len_byte;
				4'd2:    sel_byte = cmd.msg_id[7:0];
				4'd3:    sel_byte = cmd.msg_id[15:8];
				4'd4:    sel_byte = cmd.msg_id[23:16];
				4'd5:    sel_byte = cmd.msg_id[31:24];
				4'd6:    sel_byte = cmd.frag_index[7:0];
				4'd7:    sel_byte = cmd.frag_index[15:8];
				4'd10:   sel_byte = cmd.frag_total[7:0];
				4'd11:   sel_byte = cmd.frag_total[15:8];
				default: sel_byte = 8'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= cmd_valid;
			if (cmd_valid) begin
				step_q <= is_last ? '0 : step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && cmd_valid) begin
			out_byte_q   <= sel_byte;
			out_sender_q <= cmd.sender;
			packet_end_q <= is_last && cmd.pend;
			run_last_q   <= is_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign out_sender = out_sender_q;
	assign packet_end = packet_end_q;
	assign run_last   = run_last_q;

endmodule

### rtl/core/message_fragmenter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message fragmenter
// Cuts a byte-serial message into single packets or headed fragments.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one payload word per handshake, with the
// sender and total message length. Output channel (out_valid/out_ready): one
// packet byte per handshake; run_last marks the last byte caused by an input
// word, packet_end the last byte of a packet.
// Each input word yields 1 output word, 3 on the first word of a one-packet
// message, or 15 on the first word of a fragment (14 header bytes).
// The first output word passes through the front stage, the queue and the
// output register. The byte emitter produces one output word a cycle while
// the receiver takes it and holds it otherwise; the front end takes one input
// word a cycle while the four-entry command queue has room.
// Configuration (cfg_we/cfg_index/cfg_data) writes the two type bytes. The
// user must use it only while the block is idle; the block does not enforce it.
// Reset clears message id, positions and all valid flags; type bytes return
// to 0 (single) and 1 (fragment). A stalled receiver holds the output word;
// the queue then fills and in_ready drops.
// ----------------------------------------------------------------------------
module message_fragmenter_unit import mfrag_pkg::*; #(
	parameter int PACKET_SIZE = PACKET_SIZE_DEF,
	parameter int FIFO_DEPTH  = CMD_FIFO_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_byte,
	input  logic [15:0]          sender_id,
	input  logic [15:0]          message_length,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	output logic [15:0]          out_sender,
	output logic                 packet_end,
	output logic                 run_last,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	cfg_t cfg_q;
	logic fe_valid;
	logic fe_ready;
	cmd_t fe_cmd;
	logic be_valid;
	logic be_ready;
	cmd_t be_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.single_type <= SINGLE_TYPE_RST;
			cfg_q.multi_type  <= MULTI_TYPE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SINGLE_TYPE: cfg_q.single_type <= cfg_data;
				REG_MULTI_TYPE:  cfg_q.multi_type  <= cfg_data;
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	mfrag_front #(
		.PACKET_SIZE(PACKET_SIZE)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.sender_id     (sender_id),
		.message_length(message_length),
		.cfg           (cfg_q),
		.cmd_valid     (fe_valid),
		.cmd_ready     (fe_ready),
		.cmd           (fe_cmd)
	);

	mfrag_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fe_valid),
		.push_ready(fe_ready),
		.push_data (fe_cmd),
		.pop_valid (be_valid),
		.pop_ready (be_ready),
		.pop_data  (be_cmd)
	);

	mfrag_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (be_valid),
		.cmd_ready (be_ready),
		.cmd       (be_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_sender(out_sender),
		.packet_end(packet_end),
		.run_last  (run_last)
	);

	// header bytes never close a packet
	a_hdr_no_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> !packet_end)
		else $error("packet_end on a header byte");

	// a full queue behind a loaded front stage must stall the input
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		fe_valid && !fe_ready |-> !in_ready)
		else $error("input taken while front stage is blocked");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == REG_MULTI_TYPE) |=> cfg_q.multi_type == $past(cfg_data))
		else $error("fragment type byte not written");

endmodule

### verif/message_fragmenter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message fragmenter testbench
// Drives payload words through the input channel and checks every packet byte
// against a cycle-free model of the fragmenter, held as a queue of due words.
// A short table of directed words comes first. Random messages follow in three
// stall patterns, each under its own pair of type codes.
// ----------------------------------------------------------------------------
module message_fragmenter_unit_tb;
	import mfrag_pkg::*;

	localparam int SINGLE_MAX = PACKET_SIZE_DEF - 2;
	localparam int FRAG_MAX   = PACKET_SIZE_DEF - MULTI_HDR_LEN;

	typedef struct packed {
		logic [7:0]  octet;
		logic [15:0] sender;
		logic        pend;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic [7:0]  data;
		logic [15:0] sender;
		logic [15:0] len;
		logic [1:0]  n_typed;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           data_byte = '0;
	logic [15:0]          sender_id = '0;
	logic [15:0]          message_length = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [7:0]           out_byte;
	logic [15:0]          out_sender;
	logic                 packet_end;
	logic                 run_last;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data = '0;

	// model state and its copy of the type registers
	logic [7:0]  type_single = SINGLE_TYPE_RST;
	logic [7:0]  type_multi  = MULTI_TYPE_RST;
	logic [31:0] msg_id = '0;
	logic [15:0] pos_in_msg = '0;
	logic [7:0]  pos_in_frag = '0;
	logic [15:0] frag_idx = '0;
	logic [15:0] frag_cnt = '0;
	logic        splitting = 1'b0;

	out_word_t words_due[$];
	int        tx_idle_pct = 16;
	int        rx_idle_pct = 83;
	int        n_fail = 0;
	int        n_words = 0;
	int        n_out = 0;
	int        n_packets = 0;

	// Directed words. Rows with a typed count carry their expected bytes in
	// typed_words, in order; the rest are checked against the model.
	dir_row_t dir_rows [20] = '{
		'{8'h00, 16'h0000, 16'd1,     2'd3},	// one-byte message at reset codes
		'{8'hFF, 16'hFFFF, 16'd0,     2'd3},	// zero length reads as one
		'{8'hA5, 16'h1234, 16'd3,     2'd3},
		'{8'h5A, 16'h1234, 16'd3,     2'd1},
		'{8'h3C, 16'h1234, 16'd3,     2'd1},
		'{8'h11, 16'h4321, 16'd126,   2'd3},	// largest one-packet length
		'{8'h22, 16'h4321, 16'd2,     2'd1},	// length shrinks: ends here
		'{8'h33, 16'h8000, 16'd127,   2'd0},	// smallest split length
		'{8'h44, 16'h8000, 16'd1,     2'd0},
		'{8'h55, 16'h0001, 16'd65535, 2'd0},
		'{8'h66, 16'h0001, 16'd65535, 2'd0},
		'{8'h77, 16'h0001, 16'd3,     2'd0},
		'{8'h88, 16'h7FFF, 16'd40000, 2'd0},
		'{8'h99, 16'h7FFF, 16'd0,     2'd0},
		'{8'hC3, 16'hAAAA, 16'd2,     2'd0},
		'{8'h3C, 16'hAAAA, 16'd300,   2'd0},	// length grows: stays one packet
		'{8'h96, 16'hAAAA, 16'd3,     2'd0},
		'{8'h01, 16'h5555, 16'd200,   2'd0},
		'{8'h80, 16'h5555, 16'd200,   2'd0},
		'{8'h7F, 16'h5555, 16'd2,     2'd0}
	};

	out_word_t typed_words [15] = '{
		'{8'h00, 16'h0000, 1'b0, 1'b0}, '{8'h01, 16'h0000, 1'b0, 1'b0},
		'{8'h00, 16'h0000, 1'b1, 1'b1},
		'{8'h00, 16'hFFFF, 1'b0, 1'b0}, '{8'h01, 16'hFFFF, 1'b0, 1'b0},
		'{8'hFF, 16'hFFFF, 1'b1, 1'b1},
		'{8'h00, 16'h1234, 1'b0, 1'b0}, '{8'h03, 16'h1234, 1'b0, 1'b0},
		'{8'hA5, 16'h1234, 1'b0, 1'b1},
		'{8'h5A, 16'h1234, 1'b0, 1'b1},
		'{8'h3C, 16'h1234, 1'b1, 1'b1},
		'{8'h00, 16'h4321, 1'b0, 1'b0}, '{8'h7E, 16'h4321, 1'b0, 1'b0},
		'{8'h11, 16'h4321, 1'b0, 1'b1},
		'{8'h22, 16'h4321, 1'b1, 1'b1}
	};

	message_fragmenter_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.sender_id      (sender_id),
		.message_length (message_length),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.out_sender     (out_sender),
		.packet_end     (packet_end),
		.run_last       (run_last),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic out_word_t word_of(input logic [7:0] o, input logic [15:0] s,
			input logic p);
		word_of = '{octet: o, sender: s, pend: p, last: 1'b0};
	endfunction

	// Packet bytes caused by one payload word; queued when keep is set.
	function automatic void fragment_word(input logic [7:0] d, input logic [15:0] s,
			input logic [15:0] l, input bit keep);
		int          len;
		int          remaining;
		int          flen;
		bit          msg_end;
		bit          frag_end;
		logic [31:0] idx32;
		logic [31:0] cnt32;
		out_word_t   burst[$];
		len = (l == 16'd0) ? 1 : int'(l);
		remaining = (int'(pos_in_msg) < len) ? len - int'(pos_in_msg) : 1;
		msg_end = (remaining == 1);
		if (pos_in_msg == 16'd0) begin
			splitting = (len > SINGLE_MAX);
			pos_in_frag = '0;
			frag_idx = '0;
			frag_cnt = splitting ? 16'((len + FRAG_MAX - 1) / FRAG_MAX) : 16'd0;
		end
		if (!splitting) begin
			if (pos_in_msg == 16'd0) begin
				burst.insert(burst.size(), word_of(type_single, s, 1'b0));
				burst.insert(burst.size(), word_of(8'(len), s, 1'b0));
			end
			burst.insert(burst.size(), word_of(d, s, msg_end));
		end else begin
			if (pos_in_frag == 8'd0) begin
				flen = (remaining < FRAG_MAX) ? remaining : FRAG_MAX;
				idx32 = {16'h0000, frag_idx};
				cnt32 = {16'h0000, frag_cnt};
				burst.insert(burst.size(), word_of(type_multi, s, 1'b0));
				burst.insert(burst.size(), word_of(8'(flen), s, 1'b0));
				for (int i = 0; i < 4; i++)
					burst.insert(burst.size(), word_of(msg_id[8*i +: 8], s, 1'b0));
				for (int i = 0; i < 4; i++)
					burst.insert(burst.size(), word_of(idx32[8*i +: 8], s, 1'b0));
				for (int i = 0; i < 4; i++)
					burst.insert(burst.size(), word_of(cnt32[8*i +: 8], s, 1'b0));
			end
			frag_end = msg_end || (int'(pos_in_frag) + 1 >= FRAG_MAX);
			burst.insert(burst.size(), word_of(d, s, frag_end));
			if (frag_end) begin
				pos_in_frag = '0;
				frag_idx = frag_idx + 16'd1;
			end else begin
				pos_in_frag = pos_in_frag + 8'd1;
			end
		end
		if (msg_end) begin
			if (splitting)
				msg_id = msg_id + 32'd1;
			pos_in_msg = '0;
			pos_in_frag = '0;
			frag_idx = '0;
			frag_cnt = '0;
			splitting = 1'b0;
		end else begin
			pos_in_msg = pos_in_msg + 16'd1;
		end
		burst[burst.size() - 1].last = 1'b1;
		if (keep)
			foreach (burst[i])
				words_due.insert(words_due.size(), burst[i]);
	endfunction

	// Offer one word, hold it until taken, then predict from it.
	task automatic send_word(input logic [7:0] d, input logic [15:0] s,
			input logic [15:0] l, input bit keep);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		sender_id <= s;
		message_length <= l;
		do
			@(posedge clk);
		while (!in_ready);
		n_words++;
		fragment_word(d, s, l, keep);
	endtask

	task automatic random_message(input bit long_one);
		int          kind;
		int          len0;
		int          n;
		int          tail;
		bit          vary;
		logic [15:0] snd;
		logic [15:0] l;
		logic [15:0] s;
		kind = $urandom_range(0, 99);
		snd = 16'($urandom);
		vary = 1'b0;
		if (long_one) begin
			// split message sent in full, past the end of its first fragment
			len0 = $urandom_range(SINGLE_MAX + 1, SINGLE_MAX + 8);
			n = len0;
			tail = len0;
		end else if (kind < 55) begin
			len0 = $urandom_range(1, 10);
			n = len0;
			tail = len0;
		end else if (kind < 80) begin
			// split message cut short by a shrinking length
			len0 = $urandom_range(SINGLE_MAX + 1, 65535);
			n = $urandom_range(2, 6);
			tail = $urandom_range(0, n);
		end else begin
			len0 = $urandom_range(2, SINGLE_MAX);
			n = $urandom_range(2, 6);
			tail = $urandom_range(0, n);
			vary = 1'b1;
		end
		for (int p = 0; p < n; p++) begin
			if (p == 0)
				l = 16'(len0);
			else if (p == n - 1)
				l = 16'(tail);
			else if (vary)
				l = 16'($urandom_range(p + 2, 65535));
			else
				l = 16'(len0);
			// noise: any length at all, the message may run on
			if (kind >= 95 && !long_one)
				l = 16'($urandom);
			s = ($urandom_range(0, 9) == 0) ? 16'($urandom) : snd;
			send_word(8'($urandom), s, l, 1'b1);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (words_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_types(input logic [7:0] st, input logic [7:0] mt);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_SINGLE_TYPE;
		cfg_data <= st;
		@(posedge clk);
		cfg_index <= REG_MULTI_TYPE;
		cfg_data <= mt;
		@(posedge clk);
		cfg_we <= 1'b0;
		type_single = st;
		type_multi = mt;
	endtask

	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	always @(posedge clk) begin : watch_out
		out_word_t due;
		if (arst_n && out_valid && out_ready) begin
			n_out++;
			if (packet_end)
				n_packets++;
			if (words_due.size() == 0) begin
				$error("out_byte %h: output word with nothing expected", out_byte);
				n_fail++;
			end else begin
				due = words_due.pop_front();
				if (out_byte !== due.octet) begin
					$error("out_byte: expected %h, got %h", due.octet, out_byte);
					n_fail++;
				end
				if (out_sender !== due.sender) begin
					$error("out_sender: expected %h, got %h", due.sender, out_sender);
					n_fail++;
				end
				if (packet_end !== due.pend) begin
					$error("packet_end: expected %b, got %b", due.pend, packet_end);
					n_fail++;
				end
				if (run_last !== due.last) begin
					$error("run_last: expected %b, got %b", due.last, run_last);
					n_fail++;
				end
			end
		end
	end

	initial begin : stimulus
		int       t;
		int       goal;
		dir_row_t row;
		t = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			send_word(row.data, row.sender, row.len, row.n_typed == 2'd0);
			for (int k = 0; k < int'(row.n_typed); k++) begin
				words_due.insert(words_due.size(), typed_words[t]);
				t++;
			end
		end

		for (int ph = 0; ph < 3; ph++) begin
			drain();
			case (ph)
				0: begin
					write_types(8'hFF, 8'h00);
					tx_idle_pct = 16;
					rx_idle_pct = 83;
				end
				1: begin
					write_types(8'($urandom), 8'($urandom));
					tx_idle_pct = 83;
					rx_idle_pct = 16;
				end
				default: begin
					write_types(8'h00, 8'hFF);
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			// the first phase opens with a message long enough to cross a fragment
			goal = n_words + ((ph == 0) ? 130 : 10);
			if (ph == 0)
				random_message(1'b1);
			while (n_words < goal)
				random_message(1'b0);
		end

		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d input words and %0d output words in %0d packets",
			n_words, n_out, n_packets);
		$display("type codes at reset, both extremes and random; three stall patterns");
		if (n_fail == 0 && words_due.size() == 0)
			$display("message_fragmenter_unit_tb passed");
		else
			$display("message_fragmenter_unit_tb failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("message_fragmenter_unit_tb failed");
		$finish;
	end

endmodule

### sim.f
rtl/core/mfrag_pkg.sv
rtl/core/mfrag_front.sv
rtl/core/mfrag_fifo.sv
rtl/core/mfrag_back.sv
rtl/core/message_fragmenter_unit.sv
verif/message_fragmenter_unit_tb.sv
